// ----- rtl/lmsc_pkg.sv -----
// Shared types, constants, wiring table and font ROM for the LED matrix scan controller.
`timescale 1ns / 1ps

package lmsc_pkg;

    localparam int SCAN_ROWS    = 3;
    localparam int COLUMN_LINES = 9;
    localparam int GLYPH_COUNT  = 95;
    localparam int GRID_SIZE    = 5;
    localparam int PIXELS       = GRID_SIZE * GRID_SIZE;

    localparam logic [2:0] PIX_LIMIT  = 3'd5;
    localparam logic [6:0] FIRST_CODE = 7'd32;
    localparam logic [6:0] LAST_CODE  = 7'd126;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_PIXEL = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_GLYPH = 2'd3
    } t_req;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic latch;   // capture request fields
        logic exec;    // apply request to frame and drive state
    } t_dp_cmd;

    typedef logic [SCAN_ROWS-1:0][COLUMN_LINES-1:0] t_frame;
    typedef logic [39:0] t_glyph;   // five ROM bytes, row 0 in the top byte

    // per (y*5 + x): high nibble scan row, low nibble column bit
    localparam logic [7:0] WIRING [PIXELS] = '{
        8'h22, 8'h16, 8'h20, 8'h15, 8'h21,
        8'h07, 8'h06, 8'h05, 8'h04, 8'h03,
        8'h11, 8'h08, 8'h12, 8'h28, 8'h10,
        8'h23, 8'h24, 8'h25, 8'h26, 8'h27,
        8'h00, 8'h13, 8'h01, 8'h14, 8'h02
    };

    localparam t_glyph FONT_ROM [GLYPH_COUNT] = '{
        40'h0000000000, 40'h0808080008, 40'h0a4a400000, 40'h0a5fea5fea,
        40'h0ed92ed36e, 40'h1932448933, 40'h0c924c924d, 40'h0808000000,
        40'h0488080804, 40'h0804848488, 40'h000a448a40, 40'h00048ec480,
        40'h0000000488, 40'h00000ec000, 40'h0000000800, 40'h0122448810,
        40'h0c9252524c, 40'h048c84848e, 40'h1c824c901e, 40'h1ec244924c,
        40'h06ca525fe2, 40'h1ff01ec13e, 40'h02448ed12e, 40'h1fe2448810,
        40'h0ed12ed12e, 40'h0ed12ec488, 40'h0008000800, 40'h0004800488,
        40'h0244880482, 40'h000ec00ec0, 40'h0804824488, 40'h0ed126c004,
        40'h0ed135b36c, 40'h0c925ed252, 40'h1c925c925c, 40'h0ed010100e,
        40'h1c9252525c, 40'h1ed01c901e, 40'h1ed01c9010, 40'h0ed013712e,
        40'h12525ed252, 40'h1c8808081c, 40'h1fe242524c, 40'h1254981492,
        40'h101010101e, 40'h113b75b131, 40'h113935b371, 40'h0c9252524c,
        40'h1c925c9010, 40'h0c92524c86, 40'h1c925c9251, 40'h0ed00c825c,
        40'h1fe4848484, 40'h125252524c, 40'h1131312a44, 40'h113135bb71,
        40'h12524c9252, 40'h112a448484, 40'h1ec488101e, 40'h0ec808080e,
        40'h1008048241, 40'h0ec242424e, 40'h048a400000, 40'h000000001f,
        40'h0804800000, 40'h000ed2524f, 40'h10101c925c, 40'h000ed0100e,
        40'h02424ed24e, 40'h0c925c900e, 40'h06c81c8808, 40'h0ed24ec24c,
        40'h10101c9252, 40'h0800080808, 40'h024002424c, 40'h1014981492,
        40'h0808080806, 40'h001b75b131, 40'h001c925252, 40'h000c92524c,
        40'h001c925c90, 40'h000ed24ec2, 40'h000ed01010, 40'h0006c80498,
        40'h08080ec807, 40'h001252524f, 40'h0011312a44, 40'h00113135bb,
        40'h00124c8c92, 40'h00112a4498, 40'h001ec4881e, 40'h06c48c8486,
        40'h0808080808, 40'h18080c8818, 40'h00000c8360
    };

    // Map a glyph onto the frame through the wiring; unwired bits stay off.
    function automatic t_frame glyph_frame(input t_glyph g);
        t_frame     f;
        logic [7:0] w;
        f = '0;
        for (int row = 0; row < GRID_SIZE; row++) begin
            for (int col = 0; col < GRID_SIZE; col++) begin
                w = WIRING[row * GRID_SIZE + col];
                f[w[5:4]][w[3:0]] = g[8 * (GRID_SIZE - 1 - row) + (GRID_SIZE - 1 - col)];
            end
        end
        return f;
    endfunction

endpackage

// ----- rtl/lmsc_ctrl.sv -----
// Request sequencer for the LED matrix scan controller: accept, execute, strobe result.
`timescale 1ns / 1ps

module lmsc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    output lmsc_pkg::t_dp_cmd o_cmd,
    output logic              o_valid
);
    import lmsc_pkg::*;

    t_state r_state, n_state;
    logic   r_valid, n_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        busy        = (r_state != S_IDLE);
        o_cmd.latch = (r_state == S_IDLE) && start;
        o_cmd.exec  = (r_state == S_EXEC);
        n_valid     = o_cmd.exec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_valid = r_valid;

`ifndef ASSERT_OFF
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && start) |=> (r_state == S_EXEC))
        else $error("accepted request did not enter execute");
    a_exec_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> (r_valid && r_state == S_IDLE))
        else $error("execute not followed by result strobe");
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe longer than one cycle");
`endif

endmodule

// ----- rtl/lmsc_dp.sv -----
// Datapath: request capture, frame store, scan row counter and held drive registers.
`timescale 1ns / 1ps

module lmsc_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lmsc_pkg::t_dp_cmd i_cmd,
    input  logic [1:0]        i_req_type,
    input  logic [2:0]        i_x,
    input  logic [2:0]        i_y,
    input  logic              i_lit,
    input  logic [6:0]        i_char_code,
    output logic [2:0]        o_row_drive,
    output logic [8:0]        o_col_drive_n,
    output logic              o_rejected
);
    import lmsc_pkg::*;

    // captured request
    t_req       r_req;
    logic [2:0] r_x;
    logic [2:0] r_y;
    logic       r_lit;
    logic [6:0] r_code;

    t_frame     r_frame, n_frame;
    logic [1:0] r_scan_row, n_scan_row;
    logic [2:0] r_held_row, n_held_row;
    logic [8:0] r_held_cols, n_held_cols;
    logic       r_rejected, n_rejected;

    logic       pix_ok;
    logic       code_ok;
    logic [7:0] wire_pos;
    logic [6:0] glyph_idx;

    always_comb begin
        pix_ok    = (r_x < PIX_LIMIT) && (r_y < PIX_LIMIT);
        code_ok   = (r_code >= FIRST_CODE) && (r_code <= LAST_CODE);
        wire_pos  = pix_ok ? WIRING[5'(r_y) * 5'(GRID_SIZE) + 5'(r_x)] : 8'h00;
        glyph_idx = code_ok ? (r_code - FIRST_CODE) : 7'd0;
    end

    always_comb begin
        n_frame     = r_frame;
        n_scan_row  = r_scan_row;
        n_held_row  = r_held_row;
        n_held_cols = r_held_cols;
        n_rejected  = 1'b0;
        case (r_req)
            REQ_TICK: begin
                n_held_row  = 3'b001 << r_scan_row;
                n_held_cols = ~r_frame[r_scan_row];
                n_scan_row  = (r_scan_row == 2'(SCAN_ROWS - 1)) ? 2'd0 : r_scan_row + 2'd1;
            end
            REQ_PIXEL: begin
                if (pix_ok) begin
                    n_frame[wire_pos[5:4]][wire_pos[3:0]] = r_lit;
                end else begin
                    n_rejected = 1'b1;
                end
            end
            REQ_CLEAR: begin
                n_frame = '0;
            end
            REQ_GLYPH: begin
                if (code_ok) begin
                    n_frame = glyph_frame(FONT_ROM[glyph_idx]);
                end else begin
                    n_rejected = 1'b1;
                end
            end
            default: begin
                n_rejected = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req  <= t_req'(i_req_type);
            r_x    <= i_x;
            r_y    <= i_y;
            r_lit  <= i_lit;
            r_code <= i_char_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame     <= '0;
            r_scan_row  <= 2'd0;
            r_held_row  <= 3'd0;
            r_held_cols <= '1;
            r_rejected  <= 1'b0;
        end else if (i_cmd.exec) begin
            r_frame     <= n_frame;
            r_scan_row  <= n_scan_row;
            r_held_row  <= n_held_row;
            r_held_cols <= n_held_cols;
            r_rejected  <= n_rejected;
        end
    end

    assign o_row_drive   = r_held_row;
    assign o_col_drive_n = r_held_cols;
    assign o_rejected    = r_rejected;

`ifndef ASSERT_OFF
    a_row_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_held_row))
        else $error("more than one scan row driven");
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan_row != 2'd3)
        else $error("scan row out of range");
    a_unwired_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame[1][8:7] == 2'b00)
        else $error("unwired frame bit set");
    a_drive_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_cmd.exec) |=> ($stable(r_held_row) && $stable(r_held_cols)))
        else $error("drive changed without an executing request");
`endif

endmodule

// ----- rtl/led_matrix_scan_controller_core.sv -----
// Top level of the 5x5 LED matrix scan controller (3 scan rows by 9 column lines).
`timescale 1ns / 1ps

// Usage
//   Request channel: drive i_req_type/i_x/i_y/i_lit/i_char_code with start high;
//   the request is taken at a clock edge where start=1 and busy=0.
//   Request kinds: scan tick, pixel write, clear frame, glyph load (ASCII 32..126).
//   Result channel: o_valid pulses for one cycle with o_row_drive, o_col_drive_n
//   and o_rejected. There is no backpressure; the result must be taken that cycle.
//   o_row_drive/o_col_drive_n also hold steady between results and can feed
//   the matrix pins directly.
//   Sequence: from the accept edge the request passes through the execute state,
//   then the registered o_valid strobe.
//   Issue: no new request is taken while busy, set by the accept/execute handshake
//   of the sequencer; start may be held high to issue back to back. The strobe
//   cycle of one request overlaps acceptance of the next.
//   Every request, glyph load included, is applied in the execute state alone: frame store
//   is 27 flops and the font ROM is a combinational table.
//   Reset (i_rst_n low, synchronous): frame cleared, scan row 0, no row driven,
//   all columns off (high), no result pending.

module led_matrix_scan_controller_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_req_type,
    input  logic [2:0] i_x,
    input  logic [2:0] i_y,
    input  logic       i_lit,
    input  logic [6:0] i_char_code,
    output logic       o_valid,
    output logic [2:0] o_row_drive,
    output logic [8:0] o_col_drive_n,
    output logic       o_rejected
);
    import lmsc_pkg::*;

    t_dp_cmd dp_cmd;

    // sequencer: idle -> execute -> strobe
    lmsc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (dp_cmd),
        .o_valid (o_valid)
    );

    // frame store, scan counter and held drive
    lmsc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_req_type    (i_req_type),
        .i_x           (i_x),
        .i_y           (i_y),
        .i_lit         (i_lit),
        .i_char_code   (i_char_code),
        .o_row_drive   (o_row_drive),
        .o_col_drive_n (o_col_drive_n),
        .o_rejected    (o_rejected)
    );

endmodule
